// ----- rtl/ppm_frame_pulse_encoder_unit_macros.svh -----
// ----------------------------------------------------------------------------
// PPM frame pulse encoder: assertion macros
// Shared concurrent property wrappers for the encoder checks.
// ----------------------------------------------------------------------------
`ifndef PPM_FRAME_PULSE_ENCODER_UNIT_MACROS_SVH
`define PPM_FRAME_PULSE_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PPMFE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define PPMFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ppmfe_pkg.sv -----
// ----------------------------------------------------------------------------
// PPM frame pulse encoder package
// Types, register indexes and constants shared by the encoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppmfe_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_EXTENDED_LIMITS = 3'd0;
  localparam logic [2:0] REG_SYNC_DELAY_STEP = 3'd1;
  localparam logic [2:0] REG_VARIABLE_FRAME  = 3'd2;
  localparam logic [2:0] REG_FRAME_ADJUST    = 3'd3;
  localparam logic [2:0] REG_SETUP_TIME_US   = 3'd4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  // Timing constants in 2 MHz ticks
  localparam logic [10:0]        RANGE_NORMAL   = 11'd1024;
  localparam logic [10:0]        RANGE_EXTENDED = 11'd1280;
  localparam logic signed [31:0] FRAME_BASE     = 32'sd45000;
  localparam logic [15:0]        GAP_MAX        = 16'd65535;
  localparam logic [15:0]        GAP_MIN        = 16'd9000;
  localparam logic [11:0]        SYNC_BASE      = 12'd300;
  localparam logic [6:0]         SYNC_STEP      = 7'd50;
  localparam logic signed [31:0] ADJUST_UNIT    = 32'sd1000;

  // Configuration register file
  typedef struct packed {
    logic        extended_limits;
    logic [4:0]  sync_delay_step;
    logic        variable_frame;
    logic [6:0]  frame_adjust;
    logic [11:0] setup_time_us;
  } ppmfe_cfg_t;

  // One classified channel, handed from front to back
  typedef struct packed {
    logic [11:0]        sync;
    logic [15:0]        gap;
    logic               last;
    logic signed [31:0] remainder;
  } ppmfe_cmd_t;

  // Back-end word sequencer states
  typedef enum logic [4:0] {
    ST_SYNC  = 5'b00001,
    ST_GAP   = 5'b00010,
    ST_SYNC2 = 5'b00100,
    ST_FINAL = 5'b01000,
    ST_TERM  = 5'b10000
  } ppmfe_state_t;

endpackage

// ----- rtl/ppmfe_front.sv -----
// ----------------------------------------------------------------------------
// PPM frame pulse encoder: front end
// Accepts channel items, clamps and centers them, tracks the frame remainder
// and pushes one command per channel into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppmfe_front
  import ppmfe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  ppmfe_cfg_t         cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] channel_value,
  input  logic [11:0]        center_us,
  input  logic               last_channel,
  input  logic               full,
  output logic               push,
  output ppmfe_cmd_t         cmd
);

  // Stage A registers
  logic               a_valid;
  logic signed [15:0] a_v;
  logic [11:0]        a_sync;
  logic               a_last;
  logic               a_arm;
  logic signed [31:0] a_rearm;

  logic               frame_open;
  logic signed [31:0] remainder;

  logic               accept;
  logic [10:0]        range;
  logic signed [15:0] range_s;
  logic signed [15:0] clamped;
  logic signed [15:0] v_next;
  logic [11:0]        sync_next;
  logic signed [31:0] adjust;
  logic signed [31:0] rearm_next;
  logic signed [31:0] base;
  logic signed [32:0] diff;
  logic signed [31:0] rem_sat;

  assign push     = a_valid && !full;
  assign in_ready = !a_valid || push;
  assign accept   = in_valid && in_ready;

  // Clamp the channel and add twice its center
  always_comb begin
    range   = cfg.extended_limits ? RANGE_EXTENDED : RANGE_NORMAL;
    range_s = $signed({5'd0, range});
    if (channel_value > range_s) begin
      clamped = range_s;
    end else if (channel_value < -range_s) begin
      clamped = -range_s;
    end else begin
      clamped = channel_value;
    end
    v_next = clamped + $signed({3'd0, center_us, 1'b0});
  end

  // Sync width and re-arm value from the live registers
  always_comb begin
    sync_next  = 12'((SYNC_BASE + 12'(cfg.sync_delay_step) * 12'(SYNC_STEP)) << 1);
    adjust     = 32'($signed({{25{cfg.frame_adjust[6]}}, cfg.frame_adjust}) * ADJUST_UNIT);
    rearm_next = FRAME_BASE - $signed({20'd0, sync_next});
    if (cfg.variable_frame) begin
      rearm_next = rearm_next + adjust;
    end
  end

  // Update the remainder with signed 32-bit saturation
  always_comb begin
    base = a_arm ? a_rearm : remainder;
    diff = {base[31], base} - {{17{a_v[15]}}, a_v};
    if (diff[32] != diff[31]) begin
      rem_sat = diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      rem_sat = diff[31:0];
    end
    cmd.sync      = a_sync;
    cmd.gap       = 16'(a_v) - {4'd0, a_sync};
    cmd.last      = a_last;
    cmd.remainder = rem_sat;
  end

  // Stage A control
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      frame_open <= 1'b0;
      remainder  <= '0;
    end else begin
      if (accept) begin
        a_valid    <= 1'b1;
        frame_open <= !last_channel;
      end else if (push) begin
        a_valid <= 1'b0;
      end
      if (push) begin
        remainder <= rem_sat;
      end
    end
  end

  // Stage A payload
  always_ff @(posedge clk) begin
    if (accept) begin
      a_v     <= v_next;
      a_sync  <= sync_next;
      a_last  <= last_channel;
      a_arm   <= !frame_open;
      a_rearm <= rearm_next;
    end
  end

endmodule

// ----- rtl/ppmfe_queue.sv -----
// ----------------------------------------------------------------------------
// PPM frame pulse encoder: command queue
// Short FIFO of classified channels between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppmfe_queue
  import ppmfe_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ppmfe_cmd_t push_cmd,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output ppmfe_cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  ppmfe_cmd_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // Write the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/ppmfe_back.sv -----
// ----------------------------------------------------------------------------
// PPM frame pulse encoder: back end
// Walks each queued channel through its timer words into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppmfe_back
  import ppmfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [11:0] setup_time_us,
  input  logic        empty,
  input  ppmfe_cmd_t  head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] pulse_ticks,
  output logic        last_of_run,
  output logic        frame_end
);

  ppmfe_state_t state;
  ppmfe_state_t state_next;

  logic        load;
  logic        done;
  logic [15:0] word;
  logic        lor;
  logic        fend;
  logic [15:0] gap_clamped;
  logic [15:0] final_gap;

  assign load = !empty && (!out_valid || out_ready);
  assign pop  = load && done;

  // Saturate the remainder and take off the setup time
  always_comb begin
    if (head.remainder > $signed({16'd0, GAP_MAX})) begin
      gap_clamped = GAP_MAX;
    end else if (head.remainder < $signed({16'd0, GAP_MIN})) begin
      gap_clamped = GAP_MIN;
    end else begin
      gap_clamped = head.remainder[15:0];
    end
    final_gap = gap_clamped - {3'd0, setup_time_us, 1'b0};
  end

  // Select the word for this step
  always_comb begin
    word       = {4'd0, head.sync};
    lor        = 1'b0;
    fend       = 1'b0;
    done       = 1'b0;
    state_next = ST_GAP;
    unique case (state)
      ST_SYNC: begin
        state_next = ST_GAP;
      end
      ST_GAP: begin
        word       = head.gap;
        lor        = !head.last;
        done       = !head.last;
        state_next = head.last ? ST_SYNC2 : ST_SYNC;
      end
      ST_SYNC2: begin
        state_next = ST_FINAL;
      end
      ST_FINAL: begin
        word       = final_gap;
        state_next = ST_TERM;
      end
      ST_TERM: begin
        word       = '0;
        lor        = 1'b1;
        fend       = 1'b1;
        done       = 1'b1;
        state_next = ST_SYNC;
      end
      default: begin
        state_next = ST_GAP;
      end
    endcase
  end

  // Sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SYNC;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      pulse_ticks <= word;
      last_of_run <= lor;
      frame_end   <= fend;
    end
  end

endmodule

// ----- rtl/ppm_frame_pulse_encoder_unit.sv -----
// A channel item passes the front end's stage A register, a queue entry and
// the output register; its two timer words (sync, then channel gap) leave
// in turn, and the last channel of a frame yields five words (sync, gap,
// sync, final gap, zero terminator). The output register moves one word per
// cycle while the queue holds words and out_ready is high, and new items are
// taken while earlier ones still wait, unless the queue is full. A queue of QUEUE_DEPTH
// commands sits between the front end (clamp, remainder tracking) and the
// back end (word sequencer).
// ----------------------------------------------------------------------------
// PPM frame pulse encoder top level
// Configuration registers, front end, command queue and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ppm_frame_pulse_encoder_unit_macros.svh"

module ppm_frame_pulse_encoder_unit
  import ppmfe_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [15:0]     channel_value,
  input  logic [11:0]            center_us,
  input  logic                   last_channel,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [15:0]            pulse_ticks,
  output logic                   last_of_run,
  output logic                   frame_end
);

  ppmfe_cfg_t cfg;
  ppmfe_cmd_t push_cmd;
  ppmfe_cmd_t head;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.extended_limits <= 1'b0;
      cfg.sync_delay_step <= '0;
      cfg.variable_frame  <= 1'b1;
      cfg.frame_adjust    <= '0;
      cfg.setup_time_us   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXTENDED_LIMITS: cfg.extended_limits <= cfg_data[0];
        REG_SYNC_DELAY_STEP: cfg.sync_delay_step <= cfg_data[4:0];
        REG_VARIABLE_FRAME:  cfg.variable_frame  <= cfg_data[0];
        REG_FRAME_ADJUST:    cfg.frame_adjust    <= cfg_data[6:0];
        REG_SETUP_TIME_US:   cfg.setup_time_us   <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  ppmfe_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .channel_value (channel_value),
    .center_us     (center_us),
    .last_channel  (last_channel),
    .full          (full),
    .push          (push),
    .cmd           (push_cmd)
  );

  ppmfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  ppmfe_back u_back (
    .clk           (clk),
    .rst           (rst),
    .setup_time_us (cfg.setup_time_us),
    .empty         (empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pulse_ticks   (pulse_ticks),
    .last_of_run   (last_of_run),
    .frame_end     (frame_end)
  );

  // Checks
  `PPMFE_ASSERT_NOW(a_no_push_full, push, !full, "push into full queue")
  `PPMFE_ASSERT_NOW(a_no_pop_empty, pop, !empty, "pop from empty queue")
  `PPMFE_ASSERT_NOW(a_term_word, out_valid && frame_end, last_of_run && (pulse_ticks == 16'd0), "bad frame terminator")
  `PPMFE_ASSERT_NEXT(a_pop_loads, pop, out_valid && last_of_run, "pop without closing word")

endmodule
